// File: sv/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types, register indexes and helpers for the vertex projection block.
// ----------------------------------------------------------------------------
package pvp_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 63;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_FWD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_HOR = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_VER = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 4'd7;

    localparam logic signed [39:0] Q8_MAX = 40'sd8388607;
    localparam logic signed [39:0] Q8_MIN = -40'sd8388608;

    typedef struct packed {
        logic [62:0] cam;
        logic [47:0] fwd;
        logic [47:0] hor;
        logic [47:0] ver;
        logic [19:0] near;
        logic [23:0] scale;
        logic [12:0] width;
        logic [12:0] height;
    } t_cfg;

    // camera-space result handed from the transform to the projection
    typedef struct packed {
        logic        vld;
        logic [23:0] depth;
        logic [23:0] hor;
        logic [23:0] ver;
        logic        vis;
        logic [15:0] tag;
        logic [31:0] k;
    } t_cam;

    function automatic logic [23:0] sat24(input logic signed [39:0] v);
        logic [23:0] r;
        if (v > Q8_MAX) begin
            r = Q8_MAX[23:0];
        end else if (v < Q8_MIN) begin
            r = Q8_MIN[23:0];
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [19:0] near_eff(input logic [19:0] n);
        return (n == 20'd0) ? 20'd1 : n;
    endfunction

endpackage

// File: sv/pvp_xform.sv
// ----------------------------------------------------------------------------
// pvp_xform
// Three stages: camera offset, axis products, dot-product sum with rounding.
// ----------------------------------------------------------------------------
module pvp_xform import pvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [20:0] i_world_x,
    input  logic [20:0] i_world_y,
    input  logic [20:0] i_world_z,
    input  logic [15:0] i_tag,
    input  t_cfg        i_cfg,
    output t_cam        o_cam
);

    logic               r_v [2];
    logic signed [21:0] r1_d [3];
    logic [43:0]        r1_kp;
    logic [15:0]        r1_tag;
    logic signed [37:0] r2_p [3][3];
    logic [31:0]        r2_k;
    logic [15:0]        r2_tag;
    t_cam               r3;

    logic [20:0]        w [3];
    logic [47:0]        ax [3];
    logic [43:0]        kr;
    logic signed [39:0] sum [3];
    logic signed [39:0] rnd [3];
    logic [23:0]        co [3];

    assign w[0]  = i_world_x;
    assign w[1]  = i_world_y;
    assign w[2]  = i_world_z;
    assign ax[0] = i_cfg.fwd;
    assign ax[1] = i_cfg.hor;
    assign ax[2] = i_cfg.ver;
    assign kr    = r1_kp + 44'd2048;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum[a] = 40'(r2_p[a][0]) + 40'(r2_p[a][1]) + 40'(r2_p[a][2]);
            rnd[a] = (sum[a] + 40'sd8192) >>> 14;
            co[a]  = sat24(rnd[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r3.vld <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r3.vld <= r_v[1];
        end
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r1_d[c] <= $signed({w[c][20], w[c]})
                         - $signed({i_cfg.cam[21*c+20], i_cfg.cam[21*c +: 21]});
            end
            r1_kp  <= 44'(i_cfg.scale) * 44'(near_eff(i_cfg.near));
            r1_tag <= i_tag;
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_p[a][c] <= 38'(r1_d[c]) * 38'($signed(ax[a][16*c +: 16]));
                end
            end
            r2_k     <= kr[43:12];
            r2_tag   <= r1_tag;
            r3.depth <= co[0];
            r3.hor   <= co[1];
            r3.ver   <= co[2];
            r3.vis   <= $signed(co[0]) >= $signed({4'b0, near_eff(i_cfg.near)});
            r3.tag   <= r2_tag;
            r3.k     <= r2_k;
        end
    end

    assign o_cam  = r3;

endmodule

// File: sv/pvp_div.sv
// ----------------------------------------------------------------------------
// pvp_div
// Restoring divider, 24 quotient bits over six stages of four steps.
// ----------------------------------------------------------------------------
module pvp_div import pvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [47:0] i_rem,
    input  logic [23:0] i_den,
    output logic [23:0] o_quo
);

    logic [47:0] r_rem [5];
    logic [23:0] r_den [5];
    logic [23:0] r_quo [6];
    logic [47:0] n_rem [5];
    logic [23:0] n_quo [6];

    always_comb begin
        logic [47:0] rm;
        logic [23:0] qu;
        logic [23:0] dn;
        logic [47:0] trial;
        for (int s = 0; s < 6; s++) begin
            rm = (s == 0) ? i_rem : r_rem[(s == 0) ? 0 : s-1];
            qu = (s == 0) ? 24'd0 : r_quo[(s == 0) ? 0 : s-1];
            dn = (s == 0) ? i_den : r_den[(s == 0) ? 0 : s-1];
            for (int j = 0; j < 4; j++) begin
                trial = {24'd0, dn} << (23 - 4*s - j);
                if (rm >= trial) begin
                    rm = rm - trial;
                    qu[23 - 4*s - j] = 1'b1;
                end
            end
            if (s < 5) begin
                n_rem[s] = rm;
            end
            n_quo[s] = qu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < 5; s++) begin
                r_rem[s] <= n_rem[s];
            end
            for (int s = 0; s < 6; s++) begin
                r_quo[s] <= n_quo[s];
            end
            r_den[0] <= i_den;
            for (int s = 1; s < 5; s++) begin
                r_den[s] <= r_den[s-1];
            end
        end
    end

    assign o_quo = r_quo[5];

endmodule

// File: sv/pvp_proj.sv
// ----------------------------------------------------------------------------
// pvp_proj
// Scale product, dividend setup, pipelined divide and screen offset stage.
// ----------------------------------------------------------------------------
module pvp_proj import pvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cam        i_cam,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output logic [23:0] o_screen_x,
    output logic [23:0] o_screen_y,
    output logic [23:0] o_cam_depth,
    output logic [23:0] o_cam_horizontal,
    output logic [23:0] o_cam_vertical,
    output logic        o_visible,
    output logic [15:0] o_vertex_tag
);

    typedef struct packed {
        logic        vld;
        logic [23:0] depth;
        logic [23:0] hor;
        logic [23:0] ver;
        logic        vis;
        logic [15:0] tag;
        logic        ovf_x;
        logic        ovf_y;
    } t_side;

    t_side       r4_sd;
    logic [55:0] r4_px;
    logic [55:0] r4_py;
    t_side       r5_sd;
    logic [47:0] r5_rx;
    logic [47:0] r5_ry;
    logic [23:0] r5_dd;
    t_side       r_dl [6];
    logic [23:0] q_x;
    logic [23:0] q_y;
    t_side       r_out;
    logic [23:0] r_sx;
    logic [23:0] r_sy;

    logic [23:0] mag_x;
    logic [23:0] mag_y;
    logic [57:0] num_x;
    logic [57:0] num_y;
    logic [23:0] dd;
    logic [57:0] lim;
    logic [19:0] half_w;
    logic [19:0] half_h;
    t_side       sd_in;
    t_side       sd5;

    assign mag_x  = i_cam.hor[23] ? (~i_cam.hor + 24'd1) : i_cam.hor;
    assign mag_y  = i_cam.ver[23] ? (~i_cam.ver + 24'd1) : i_cam.ver;
    assign dd     = {r4_sd.depth[22:0], 1'b0};
    assign num_x  = {1'b0, r4_px, 1'b0} + {34'd0, r4_sd.depth};
    assign num_y  = {1'b0, r4_py, 1'b0} + {34'd0, r4_sd.depth};
    assign lim    = {10'd0, dd, 24'd0};
    assign half_w = {i_cfg.width[12:1], 8'd0};
    assign half_h = {i_cfg.height[12:1], 8'd0};

    always_comb begin
        sd_in       = '0;
        sd_in.vld   = i_cam.vld;
        sd_in.depth = i_cam.depth;
        sd_in.hor   = i_cam.hor;
        sd_in.ver   = i_cam.ver;
        sd_in.vis   = i_cam.vis;
        sd_in.tag   = i_cam.tag;
        sd5         = r4_sd;
        sd5.ovf_x   = num_x >= lim;
        sd5.ovf_y   = num_y >= lim;
    end

    // subtract the signed term from the half size, saturate, zero if hidden
    function automatic logic [23:0] place(input logic [19:0] half, input logic neg,
                                          input logic ovf, input logic [23:0] q,
                                          input logic vis);
        logic signed [39:0] t;
        logic [23:0]        r;
        t = neg ? (40'(half) + 40'(q)) : (40'(half) - 40'(q));
        if (!vis) begin
            r = 24'd0;
        end else if (ovf) begin
            r = neg ? Q8_MAX[23:0] : Q8_MIN[23:0];
        end else begin
            r = sat24(t);
        end
        return r;
    endfunction

    pvp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (r5_rx),
        .i_den (r5_dd),
        .o_quo (q_x)
    );

    pvp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (r5_ry),
        .i_den (r5_dd),
        .o_quo (q_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_sd.vld <= 1'b0;
            r5_sd.vld <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_dl[i].vld <= 1'b0;
            end
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r4_sd <= sd_in;
            r4_px <= 56'(i_cam.k) * 56'(mag_x);
            r4_py <= 56'(i_cam.k) * 56'(mag_y);
            r5_sd <= sd5;
            r5_rx <= num_x[47:0];
            r5_ry <= num_y[47:0];
            r5_dd <= dd;
            r_dl[0] <= r5_sd;
            for (int i = 1; i < 6; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
            r_out <= r_dl[5];
            r_sx  <= place(half_w, r_dl[5].hor[23], r_dl[5].ovf_x, q_x, r_dl[5].vis);
            r_sy  <= place(half_h, r_dl[5].ver[23], r_dl[5].ovf_y, q_y, r_dl[5].vis);
        end
    end

    assign o_valid          = r_out.vld;
    assign o_screen_x       = r_sx;
    assign o_screen_y       = r_sy;
    assign o_cam_depth      = r_out.depth;
    assign o_cam_horizontal = r_out.hor;
    assign o_cam_vertical   = r_out.ver;
    assign o_visible        = r_out.vis;
    assign o_vertex_tag     = r_out.tag;

endmodule

// File: sv/perspective_vertex_projection.sv
// Throughput: one vertex per cycle when not stalled; the 24-step divide spans six stages.
// The whole pipeline advances together and holds while the output waits.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Configuration writes are always accepted; issue them only with no vertex in flight.
// ----------------------------------------------------------------------------
// perspective_vertex_projection
// Camera transform and perspective projection of one vertex per cycle when not stalled.
// ----------------------------------------------------------------------------
module perspective_vertex_projection import pvp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [20:0]           i_world_x,
    input  logic [20:0]           i_world_y,
    input  logic [20:0]           i_world_z,
    input  logic [15:0]           i_vertex_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [23:0]           o_screen_x,
    output logic [23:0]           o_screen_y,
    output logic [23:0]           o_cam_depth,
    output logic [23:0]           o_cam_horizontal,
    output logic [23:0]           o_cam_vertical,
    output logic                  o_visible,
    output logic [15:0]           o_vertex_tag
);

    t_cfg r_cfg;
    t_cam cam;
    logic en;

    // advance every stage unless a finished result is still waiting
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // register file: write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam    <= '0;
            r_cfg.fwd    <= 48'd16384;
            r_cfg.hor    <= 48'd1073741824;
            r_cfg.ver    <= 48'd70368744177664;
            r_cfg.near   <= 20'd256;
            r_cfg.scale  <= 24'd163840;
            r_cfg.width  <= 13'd640;
            r_cfg.height <= 13'd480;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAMERA:   r_cfg.cam    <= i_cfg_data;
                CFG_AXIS_FWD: r_cfg.fwd    <= i_cfg_data[47:0];
                CFG_AXIS_HOR: r_cfg.hor    <= i_cfg_data[47:0];
                CFG_AXIS_VER: r_cfg.ver    <= i_cfg_data[47:0];
                CFG_NEAR:     r_cfg.near   <= i_cfg_data[19:0];
                CFG_SCALE:    r_cfg.scale  <= i_cfg_data[23:0];
                CFG_WIDTH:    r_cfg.width  <= i_cfg_data[12:0];
                CFG_HEIGHT:   r_cfg.height <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // stages 1-3: offset, axis products, rounded dot products
    pvp_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_in_valid),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .i_tag     (i_vertex_index),
        .i_cfg     (r_cfg),
        .o_cam     (cam)
    );

    // stages 4-12: scale product, divide, screen offset; last stage is the output register
    pvp_proj u_proj (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_cam            (cam),
        .i_cfg            (r_cfg),
        .o_valid          (o_out_valid),
        .o_screen_x       (o_screen_x),
        .o_screen_y       (o_screen_y),
        .o_cam_depth      (o_cam_depth),
        .o_cam_horizontal (o_cam_horizontal),
        .o_cam_vertical   (o_cam_vertical),
        .o_visible        (o_visible),
        .o_vertex_tag     (o_vertex_tag)
    );

`ifndef SYNTH
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_visible |-> o_screen_x == 24'd0 && o_screen_y == 24'd0)
        else $error("hidden vertex with nonzero screen position");

    a_visible_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_visible |-> !o_cam_depth[23] && o_cam_depth != 24'd0)
        else $error("visible vertex without positive depth");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule
